// ===== design/assert_macros.svh =====
// Assertion macros for the checker of the depth unpacker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define PDUL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define PDUL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pdul_pkg.sv =====
// Types and constants shared by the packed depth unpacker modules.
`timescale 1ns / 1ps

package pdul_pkg;

	localparam int TABLE_ENTRIES = 2048;
	localparam int CODE_W = 11;
	localparam int MM_W = 13;

	localparam logic [MM_W-1:0] MM_MAX = 13'd8191;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [7:0] SKIP_A = 8'd73;
	localparam logic [7:0] SKIP_B = 8'd146;
	localparam logic [7:0] LAST_MID = 8'd219;

	localparam logic [3:0] WIN_ADD_MID = 4'd8;
	localparam logic [3:0] WIN_ADD_HIGH = 4'd4;

	localparam int GROUP_BYTES = 22;
	localparam logic [4:0] HALF_BYTES = 5'd11;

	localparam logic [11:0] DIV22_MUL = 12'd2979;

	localparam logic [3:0] POS_SLOT0 = 4'd1;
	localparam logic [3:0] POS_SLOT1 = 4'd4;
	localparam logic [3:0] POS_SLOT2 = 4'd6;
	localparam logic [3:0] POS_SLOT3 = 4'd9;

	typedef struct packed {
		logic op;
		logic [CODE_W-1:0] idx;
		logic [MM_W-1:0] val;
		logic inwin;
		logic [7:0] row;
		logic [10:0] rel;
		logic [7:0] cur;
		logic [7:0] b1;
		logic [7:0] b2;
	} s1_t;

	typedef struct packed {
		s1_t pre;
		logic [6:0] grp;
	} s2_t;

	typedef struct packed {
		logic load;
		logic [CODE_W-1:0] idx;
		logic [MM_W-1:0] val;
		logic emit;
		logic [7:0] row;
		logic [8:0] col;
		logic [CODE_W-1:0] code;
	} s3_t;

endpackage

// ===== design/pdul_lut_mem.sv =====
// Code table RAM with separate write and read ports and a registered read port.
`timescale 1ns / 1ps

module pdul_lut_mem import pdul_pkg::*; (
	input logic clk,
	input logic wr_en,
	input logic [CODE_W-1:0] wr_addr,
	input logic [MM_W-1:0] wr_data,
	input logic rd_en,
	input logic [CODE_W-1:0] rd_addr,
	output logic [MM_W-1:0] rd_data
);

	logic [MM_W-1:0] mem [TABLE_ENTRIES];
	logic [MM_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== design/pdul_window.sv =====
// Input stage: packet classification, window offset, byte history and load saturation.
`timescale 1ns / 1ps

module pdul_window import pdul_pkg::*; #(
	parameter int FRAME_WIDTH = 320,
	parameter int FRAME_ROWS = 240
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic op,
	input logic [10:0] table_index,
	input logic [15:0] table_value,
	input logic [7:0] packet_number,
	input logic [10:0] byte_position,
	input logic [7:0] data_byte,
	output s1_t s1
);

	localparam logic [8:0] ROW_LIM = 9'(FRAME_ROWS);
	localparam logic [10:0] WIN_LIM = 11'((FRAME_WIDTH / 8) * GROUP_BYTES);

	logic [7:0] prev_q;
	logic [7:0] prev2_q;
	logic skip;
	logic [7:0] row;
	logic [7:0] base;
	logic [3:0] add;
	logic [10:0] offset;
	logic [10:0] rel;
	logic row_ok;
	logic win_ok;
	logic [MM_W-1:0] sat_val;

	always_comb begin
		skip = (packet_number == SKIP_A) || (packet_number == SKIP_B);
		priority if (packet_number > LAST_MID) begin
			row = packet_number - 8'd2;
			base = packet_number - (LAST_MID + 8'd1);
			add = 4'd0;
		end else if (packet_number > SKIP_B) begin
			row = packet_number - 8'd2;
			base = packet_number - (SKIP_B + 8'd1);
			add = WIN_ADD_HIGH;
		end else if (packet_number > SKIP_A) begin
			row = packet_number - 8'd1;
			base = packet_number - (SKIP_A + 8'd1);
			add = WIN_ADD_MID;
		end else begin
			row = packet_number;
			base = packet_number;
			add = 4'd0;
		end
		offset = {base, 3'b000} + {1'b0, base, 2'b00} + {7'd0, add};
		rel = byte_position - offset;
		row_ok = {1'b0, row} < ROW_LIM;
		win_ok = (byte_position >= offset) && (rel < WIN_LIM);
		if (table_index == '0) begin
			sat_val = '0;
		end else if (table_value > {3'd0, MM_MAX}) begin
			sat_val = MM_MAX;
		end else begin
			sat_val = table_value[MM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			prev2_q <= '0;
		end else if (accept && op == OP_PIXEL) begin
			prev_q <= data_byte;
			prev2_q <= prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1.op <= op;
			s1.idx <= table_index;
			s1.val <= sat_val;
			s1.inwin <= !skip && row_ok && win_ok;
			s1.row <= row;
			s1.rel <= rel;
			s1.cur <= data_byte;
			s1.b1 <= prev_q;
			s1.b2 <= prev2_q;
		end
	end

endmodule

// ===== design/pdul_unpack.sv =====
// Group split by reciprocal multiply and 11-bit code extraction.
`timescale 1ns / 1ps

module pdul_unpack import pdul_pkg::*; (
	input logic clk,
	input logic load_s2,
	input logic load_s3,
	input s1_t s1,
	output s3_t s3
);

	s2_t s2;
	logic [22:0] prod;
	logic [10:0] grp22;
	logic [4:0] k;
	logic half;
	logic [3:0] kk;
	logic hit;
	logic [1:0] slot;
	logic [CODE_W-1:0] code;
	logic [9:0] col_full;

	assign prod = 23'(s1.rel) * 23'(DIV22_MUL);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			s2.pre <= s1;
			s2.grp <= prod[22:16];
		end
	end

	always_comb begin
		grp22 = {s2.grp, 4'b0000} + {2'b00, s2.grp, 2'b00} + {3'b000, s2.grp, 1'b0};
		k = 5'(s2.pre.rel - grp22);
		half = k >= HALF_BYTES;
		kk = half ? 4'(k - HALF_BYTES) : k[3:0];
		hit = 1'b1;
		slot = 2'd0;
		code = '0;
		unique case (kk)
			POS_SLOT0: begin
				code = {s2.pre.b1, s2.pre.cur[7:5]};
				slot = 2'd0;
			end
			POS_SLOT1: begin
				code = {s2.pre.b2[1:0], s2.pre.b1, s2.pre.cur[7]};
				slot = 2'd1;
			end
			POS_SLOT2: begin
				code = {s2.pre.b1[3:0], s2.pre.cur[7:1]};
				slot = 2'd2;
			end
			POS_SLOT3: begin
				code = {s2.pre.b1[5:0], s2.pre.cur[7:3]};
				slot = 2'd3;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		col_full = {s2.grp, half, slot};
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			s3.load <= s2.pre.op == OP_LOAD;
			s3.idx <= s2.pre.idx;
			s3.val <= s2.pre.val;
			s3.emit <= (s2.pre.op == OP_PIXEL) && s2.pre.inwin && hit;
			s3.row <= s2.pre.row;
			s3.col <= col_full[8:0];
			s3.code <= code;
		end
	end

endmodule

// ===== design/packed_depth_unpack_lut.sv =====
// Top level of the packed 11-bit depth unpacker with its millimetre lookup table.
`timescale 1ns / 1ps

// The block takes one word per clock, whether a table load or a packet byte, until
// an output stall backs up into the input. A pixel passes the input stage, the
// reciprocal-multiply group split, the code extraction stage and the table RAM
// read, whose registered data forms the output register. Loads and lookups reach
// the RAM in the same stage, in arrival order, so a lookup always sees every load
// accepted before it. While a pixel waits at the output, words keep moving through
// the three stages behind it, and the input stalls only once a second pixel has
// reached the table read with both stages before it full. Table entries never
// loaded read as arbitrary values.
module packed_depth_unpack_lut import pdul_pkg::*; #(
	parameter int FRAME_WIDTH = 320,
	parameter int FRAME_ROWS = 240
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [10:0] table_index,
	input logic [15:0] table_value,
	input logic [7:0] packet_number,
	input logic [10:0] byte_position,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] pixel_row,
	output logic [8:0] pixel_column,
	output logic [12:0] depth_mm
);

	s1_t s1;
	s3_t s3;
	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;
	logic en1;
	logic en2;
	logic en3;
	logic en4;
	logic s3_go;
	logic [7:0] row_s4;
	logic [8:0] col_s4;

	assign en4 = !v4_q || out_ready;
	assign s3_go = v3_q && (!s3.emit || en4);
	assign en3 = !v3_q || s3_go;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= in_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en4) begin
				v4_q <= v3_q && s3.emit;
			end
		end
	end

	pdul_window #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_ROWS(FRAME_ROWS)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_valid && en1),
		.op(op),
		.table_index(table_index),
		.table_value(table_value),
		.packet_number(packet_number),
		.byte_position(byte_position),
		.data_byte(data_byte),
		.s1(s1)
	);

	pdul_unpack u_unpack (
		.clk(clk),
		.load_s2(en2 && v1_q),
		.load_s3(en3 && v2_q),
		.s1(s1),
		.s3(s3)
	);

	pdul_lut_mem u_lut (
		.clk(clk),
		.wr_en(v3_q && s3.load),
		.wr_addr(s3.idx),
		.wr_data(s3.val),
		.rd_en(v3_q && s3.emit && en4),
		.rd_addr(s3.code),
		.rd_data(depth_mm)
	);

	always_ff @(posedge clk) begin
		if (en4 && v3_q && s3.emit) begin
			row_s4 <= s3.row;
			col_s4 <= s3.col;
		end
	end

	assign out_valid = v4_q;
	assign pixel_row = row_s4;
	assign pixel_column = col_s4;

endmodule

// ===== design/pdul_checker.sv =====
// Port-level checker for the depth unpacker and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pdul_checker #(
	parameter int FRAME_WIDTH = 320,
	parameter int FRAME_ROWS = 240
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [7:0] pixel_row,
	input logic [8:0] pixel_column,
	input logic [12:0] depth_mm
);

	`PDUL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_row) && $stable(pixel_column) && $stable(depth_mm), "Stalled output word changed.")

	`PDUL_ASSERT_IMPL(a_stall_only_from_output, clk, arst_n, !in_ready, out_valid && !out_ready, "Input stalled without an output stall.")

	`PDUL_ASSERT_IMPL(a_row_range, clk, arst_n, out_valid, int'(pixel_row) < FRAME_ROWS, "Pixel row beyond the frame.")

	`PDUL_ASSERT_IMPL(a_col_range, clk, arst_n, out_valid, int'(pixel_column) < FRAME_WIDTH, "Pixel column beyond the frame.")

endmodule

bind packed_depth_unpack_lut pdul_checker #(
	.FRAME_WIDTH(FRAME_WIDTH),
	.FRAME_ROWS(FRAME_ROWS)
) u_pdul_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.pixel_row(pixel_row),
	.pixel_column(pixel_column),
	.depth_mm(depth_mm)
);
